FILE: design/fsmk_pkg.sv
// ----------------------------------------------------------------------------
// fsmk_pkg: shared types and constants
// Operation codes, field widths and the token that moves along the cell chain.
// ----------------------------------------------------------------------------
package fsmk_pkg;

  localparam int PTIME_W = 16;
  localparam int MACH_W  = 4;
  localparam int COMP_W  = 26;
  localparam int CFG_W   = 5;

  localparam logic [COMP_W-1:0] COMP_CAP = {COMP_W{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SEQ   = 1'b1
  } op_t;

  typedef struct packed {
    logic               v;
    op_t                op;
    logic               last;
    logic [MACH_W-1:0]  machine;
    logic [PTIME_W-1:0] ptime;
  } tok_t;

endpackage

FILE: design/fsmk_cell.sv
// ----------------------------------------------------------------------------
// fsmk_cell: one machine of the flow shop chain
// Holds the machine's column of processing times and its completion time,
// and registers each token before handing it on to the next machine.
// ----------------------------------------------------------------------------
module fsmk_cell #(
  parameter int JOBS  = 64,
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fsmk_pkg::tok_t                      up_tok,
  input  logic [$clog2(JOBS)-1:0]             up_job,
  input  logic [fsmk_pkg::COMP_W-1:0]         up_comp,
  input  logic                                active,
  input  logic                                is_final,
  output fsmk_pkg::tok_t                      tok,
  output logic [$clog2(JOBS)-1:0]             job,
  output logic [fsmk_pkg::COMP_W-1:0]         comp,
  output logic                                res_v,
  output logic [fsmk_pkg::COMP_W-1:0]         res_done
);
  import fsmk_pkg::*;

  logic [PTIME_W-1:0] mem [JOBS];
  logic [PTIME_W-1:0] rdata;
  logic               fresh;
  logic [COMP_W-1:0]  start;
  logic [COMP_W:0]    sum;
  logic [COMP_W-1:0]  done;
  logic               do_seq;

  // table write travels in order with the jobs, so reads see program order
  always_ff @(posedge clk) begin
    if (up_tok.v && up_tok.op == OP_WRITE && 32'(up_tok.machine) == INDEX) begin
      mem[up_job] <= up_tok.ptime;
    end
    rdata <= mem[up_job];
  end

  always_comb begin
    start = fresh ? '0 : comp;
    if (up_comp > start) begin
      start = up_comp;
    end
    sum  = {1'b0, start} + (COMP_W+1)'(rdata);
    done = sum[COMP_W] ? COMP_CAP : sum[COMP_W-1:0];
  end

  assign do_seq   = tok.v && tok.op == OP_SEQ;
  assign res_v    = do_seq && tok.last && is_final;
  assign res_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.v <= 1'b0;
      fresh <= 1'b1;
    end else begin
      tok.v <= up_tok.v;
      // a closing job clears every machine, in use or not
      if (do_seq && (active || tok.last)) begin
        fresh <= tok.last;
      end
    end
    tok.op      <= up_tok.op;
    tok.last    <= up_tok.last;
    tok.machine <= up_tok.machine;
    tok.ptime   <= up_tok.ptime;
    job         <= up_job;
    if (do_seq && active) begin
      comp <= done;
    end
  end

endmodule

FILE: design/flow_shop_makespan_unit.sv
// ----------------------------------------------------------------------------
// flow_shop_makespan_unit: permutation flow shop makespan evaluator
// Chain of one cell per machine; table writes and jobs pass down the chain.
// ----------------------------------------------------------------------------
// Table writes (op 0) and jobs of a sequence (op 1) are accepted one per
// cycle and move down a chain of MAX_MACHINES cells, one cell per cycle; each
// cell keeps its machine's processing times and completion time. A job that
// closes a sequence (last) raises out_valid after it has passed the last machine
// in use (a count of zero acts as one, a count above
// MAX_MACHINES as MAX_MACHINES), and no further input is taken from that
// transfer until the makespan has been transferred out. Completion times
// saturate at 2^26-1. The completion row starts out zero and is cleared after
// each sequence; processing times are undefined until written.
module flow_shop_makespan_unit #(
  parameter int MAX_JOBS     = 64,
  parameter int MAX_MACHINES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fsmk_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [5:0]                      job,
  input  logic [fsmk_pkg::MACH_W-1:0]     machine,
  input  logic [fsmk_pkg::PTIME_W-1:0]    proc_time,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fsmk_pkg::COMP_W-1:0]     makespan
);
  import fsmk_pkg::*;

  localparam int JW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_MACHINES + 1);

  logic [CFG_W-1:0]  machines_in_use;
  logic [CW-1:0]     cnt_eff;
  logic              busy;
  logic              accept;

  tok_t              tok_in;
  logic [JW-1:0]     job_in;
  tok_t              tok_c  [MAX_MACHINES+1];
  logic [JW-1:0]     job_c  [MAX_MACHINES+1];
  logic [COMP_W-1:0] comp_c [MAX_MACHINES+1];
  logic              res_v    [MAX_MACHINES];
  logic [COMP_W-1:0] res_done [MAX_MACHINES];
  logic              res_any;
  logic [COMP_W-1:0] res_val;

  function automatic logic [JW-1:0] job_wrap(input logic [5:0] j);
    logic [5:0] r;
    int         k;
    r = j;
    for (k = 5; k >= 0; k--) begin
      if ((MAX_JOBS << k) <= 63 && 32'(r) >= (MAX_JOBS << k)) begin
        r = r - 6'(MAX_JOBS << k);
      end
    end
    return JW'(r);
  endfunction

  always_comb begin
    if (machines_in_use == '0) begin
      cnt_eff = CW'(1);
    end else if (32'(machines_in_use) > MAX_MACHINES) begin
      cnt_eff = CW'(MAX_MACHINES);
    end else begin
      cnt_eff = CW'(machines_in_use);
    end
  end

  assign in_ready = !busy && !out_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tok_in.v       = accept;
    tok_in.op      = op_t'(op);
    tok_in.last    = last;
    tok_in.machine = machine;
    tok_in.ptime   = proc_time;
    job_in         = job_wrap(job);
  end

  assign tok_c[0]  = tok_in;
  assign job_c[0]  = job_in;
  assign comp_c[0] = '0;

  for (genvar i = 0; i < MAX_MACHINES; i++) begin : g_cell
    fsmk_cell #(
      .JOBS  (MAX_JOBS),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_tok   (tok_c[i]),
      .up_job   (job_c[i]),
      .up_comp  (comp_c[i]),
      .active   (CW'(i) < cnt_eff),
      .is_final (CW'(i + 1) == cnt_eff),
      .tok      (tok_c[i+1]),
      .job      (job_c[i+1]),
      .comp     (comp_c[i+1]),
      .res_v    (res_v[i]),
      .res_done (res_done[i])
    );
  end

  always_comb begin
    res_any = 1'b0;
    res_val = '0;
    for (int i = 0; i < MAX_MACHINES; i++) begin
      res_any = res_any | res_v[i];
      res_val = res_val | (res_v[i] ? res_done[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machines_in_use <= CFG_W'(1);
      busy            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        machines_in_use <= cfg_data;
      end
      if (accept && op_t'(op) == OP_SEQ && last) begin
        busy <= 1'b1;
      end else if (res_any) begin
        busy <= 1'b0;
      end
      if (res_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (res_any) begin
      makespan <= res_val;
    end
  end

endmodule
